// File: design/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the chunked container deframer
// Item structs, phase encoding, status and kind codes, header words.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int WORD_BITS           = 32;
    localparam int HDR_BYTES           = 12;
    localparam int CHUNK_HDR_BYTES     = 8;
    localparam int MANIFEST_POS        = HDR_BYTES + CHUNK_HDR_BYTES;
    localparam int MAGIC_END_POS       = 4;
    localparam int VERSION_END_POS     = 8;
    localparam int LEN_WORD_COUNT      = 4;

    // header words as assembled little-endian
    localparam logic [WORD_BITS-1:0] MAGIC_WORD    = 32'h5258_4346;
    localparam logic [WORD_BITS-1:0] TYPE_MANIFEST = 32'h4E4F_534A;
    localparam logic [WORD_BITS-1:0] TYPE_BINARY   = 32'h004E_4942;
    localparam logic [WORD_BITS-1:0] TYPE_IMAGE    = 32'h0047_4E50;

    localparam logic [WORD_BITS-1:0] VERSION_RESET = 32'd1;

    typedef enum logic [2:0] {
        PHASE_HEADER = 3'd0,
        PHASE_CHUNK  = 3'd1,
        PHASE_PAY    = 3'd2,
        PHASE_PAD    = 3'd3,
        PHASE_DRAIN  = 3'd4,
        PHASE_DONE   = 3'd5
    } phase_t;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_MANIFEST = 3'd1;
    localparam logic [2:0] KIND_BINARY   = 3'd2;
    localparam logic [2:0] KIND_IMAGE    = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

    localparam logic [3:0] STATUS_BUSY          = 4'd0;
    localparam logic [3:0] STATUS_ACCEPTED      = 4'd1;
    localparam logic [3:0] STATUS_SHORT         = 4'd2;
    localparam logic [3:0] STATUS_MAGIC         = 4'd3;
    localparam logic [3:0] STATUS_VERSION       = 4'd4;
    localparam logic [3:0] STATUS_TOTAL_SMALL   = 4'd5;
    localparam logic [3:0] STATUS_TOTAL_EXCEEDS = 4'd6;
    localparam logic [3:0] STATUS_OVERRUN       = 4'd7;
    localparam logic [3:0] STATUS_MANIFEST_TWICE = 4'd8;
    localparam logic [3:0] STATUS_MANIFEST_LATE = 4'd9;
    localparam logic [3:0] STATUS_BINARY_TWICE  = 4'd10;
    localparam logic [3:0] STATUS_NO_MANIFEST   = 4'd11;
    localparam logic [3:0] STATUS_IGNORED       = 4'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [2:0] chunk_kind;
        logic       chunk_last;
        logic [3:0] status;
    } out_item_t;

endpackage

`default_nettype wire

// File: design/chunked_container_deframer_top.sv
// ----------------------------------------------------------------------------
// chunked_container_deframer_top: byte-serial tagged chunk container parser
// Checks the file header, walks chunk headers, tags payload bytes.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered in the output register, or in the skid entry while the output is held.
// Throughput: 1 byte per cycle while the skid entry is empty; the parse state updates in a single pass.
// A two-entry output buffer keeps input accepting while one result waits.
// Reset: async active low; parser returns to header phase, version reg = 1.
`default_nettype none

module chunked_container_deframer_top #(
    parameter int LENGTH_BITS = ccd_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ccd_pkg::in_item_t in_data,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output ccd_pkg::out_item_t    out_data,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [ccd_pkg::WORD_BITS-1:0] cfg_data
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] POS_MAGIC_END   = LB'(ccd_pkg::MAGIC_END_POS);
    localparam logic [LB-1:0] POS_VERSION_END = LB'(ccd_pkg::VERSION_END_POS);
    localparam logic [LB-1:0] POS_HDR_END     = LB'(ccd_pkg::HDR_BYTES);
    localparam logic [LB-1:0] POS_MANIFEST    = LB'(ccd_pkg::MANIFEST_POS);
    localparam logic [LB:0]   CHDR_LEN        = (LB+1)'(ccd_pkg::CHUNK_HDR_BYTES);
    localparam logic [ccd_pkg::WORD_BITS-1:0] HDR_MIN = 32'(ccd_pkg::HDR_BYTES);

    // configuration
    logic [ccd_pkg::WORD_BITS-1:0] version_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= ccd_pkg::VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            version_reg <= cfg_data;
        end
    end

    // parse state
    ccd_pkg::phase_t               phase_reg, phase_next;
    logic [LB-1:0]                 byte_pos_reg, byte_pos_next;
    logic [LB-1:0]                 total_reg, total_next;
    logic [ccd_pkg::WORD_BITS-1:0] word_shift_reg, word_shift_next;
    logic [2:0]                    hdr_count_reg, hdr_count_next;
    logic [LB-1:0]                 pay_left_reg, pay_left_next;
    logic                          len_big_reg, len_big_next;
    logic [1:0]                    pad_left_reg, pad_left_next;
    logic [2:0]                    cur_kind_reg, cur_kind_next;
    logic                          manifest_seen_reg, manifest_seen_next;
    logic                          binary_seen_reg, binary_seen_next;
    logic [3:0]                    final_status_reg, final_status_next;

    logic                          accept;
    ccd_pkg::out_item_t            result;

    logic [LB-1:0]                 bp_inc;
    logic [ccd_pkg::WORD_BITS-1:0] ws_shift;
    logic                          ws_big;
    logic [LB:0]                   bp_plus_hdr;
    logic                          bound_run;
    logic                          bound_hdr;
    logic [LB-1:0]                 remaining;
    logic                          overrun;
    logic [LB-1:0]                 pay_dec;
    logic [1:0]                    pad_dec;
    logic                          finished;
    logic [3:0]                    chunk_err;
    logic [2:0]                    chunk_kind;

    logic                          skid_valid_reg;

    assign accept      = in_valid && !skid_valid_reg;
    assign in_stall    = skid_valid_reg;

    assign bp_inc      = byte_pos_reg + LB'(1);
    assign ws_shift    = {in_data.data_byte, word_shift_reg[ccd_pkg::WORD_BITS-1:8]};
    assign ws_big      = (ws_shift >> LB) != '0;
    assign bp_plus_hdr = {1'b0, bp_inc} + CHDR_LEN;
    assign bound_run   = bp_plus_hdr <= {1'b0, total_reg};
    assign bound_hdr   = bp_plus_hdr <= {1'b0, ws_shift[LB-1:0]};
    assign remaining   = total_reg - bp_inc;
    assign overrun     = len_big_reg || (pay_left_reg > remaining);
    assign pay_dec     = pay_left_reg - LB'(1);
    assign pad_dec     = pad_left_reg - 2'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_pos_next      = byte_pos_reg;
        total_next         = total_reg;
        word_shift_next    = word_shift_reg;
        hdr_count_next     = hdr_count_reg;
        pay_left_next      = pay_left_reg;
        len_big_next       = len_big_reg;
        pad_left_next      = pad_left_reg;
        cur_kind_next      = cur_kind_reg;
        manifest_seen_next = manifest_seen_reg;
        binary_seen_next   = binary_seen_reg;
        final_status_next  = final_status_reg;
        result             = '0;
        finished           = 1'b0;
        chunk_err          = ccd_pkg::STATUS_BUSY;
        chunk_kind         = ccd_pkg::KIND_UNKNOWN;

        if (accept)
        begin
            if (phase_reg == ccd_pkg::PHASE_DONE)
            begin
                result.status = ccd_pkg::STATUS_IGNORED;
                finished      = 1'b1;
            end
            else
            begin
                byte_pos_next = bp_inc;
                case (phase_reg)
                    ccd_pkg::PHASE_HEADER:
                    begin
                        word_shift_next = ws_shift;
                        if (bp_inc == POS_MAGIC_END && ws_shift != ccd_pkg::MAGIC_WORD)
                        begin
                            final_status_next = ccd_pkg::STATUS_MAGIC;
                        end
                        if (bp_inc == POS_VERSION_END
                            && final_status_next == ccd_pkg::STATUS_BUSY
                            && ws_shift != version_reg)
                        begin
                            final_status_next = ccd_pkg::STATUS_VERSION;
                        end
                        if (bp_inc == POS_HDR_END)
                        begin
                            if (final_status_next == ccd_pkg::STATUS_BUSY)
                            begin
                                if (ws_shift < HDR_MIN)
                                begin
                                    final_status_next = ccd_pkg::STATUS_TOTAL_SMALL;
                                end
                                else if (ws_big)
                                begin
                                    final_status_next = ccd_pkg::STATUS_TOTAL_EXCEEDS;
                                end
                            end
                            if (final_status_next != ccd_pkg::STATUS_BUSY)
                            begin
                                result.status = final_status_next;
                                phase_next    = ccd_pkg::PHASE_DONE;
                                finished      = 1'b1;
                            end
                            else
                            begin
                                total_next = ws_shift[LB-1:0];
                                if (bound_hdr)
                                begin
                                    phase_next     = ccd_pkg::PHASE_CHUNK;
                                    hdr_count_next = 3'd0;
                                end
                                else
                                begin
                                    phase_next = ccd_pkg::PHASE_DRAIN;
                                end
                            end
                        end
                    end

                    ccd_pkg::PHASE_CHUNK:
                    begin
                        word_shift_next = ws_shift;
                        hdr_count_next  = hdr_count_reg + 3'd1;
                        if (hdr_count_next == 3'(ccd_pkg::LEN_WORD_COUNT))
                        begin
                            pay_left_next = ws_shift[LB-1:0];
                            len_big_next  = ws_big;
                        end
                        if (hdr_count_next == 3'd0)
                        begin
                            // chunk header complete: length in pay_left, type in ws_shift
                            if (overrun)
                            begin
                                chunk_err = ccd_pkg::STATUS_OVERRUN;
                            end
                            else if (ws_shift == ccd_pkg::TYPE_MANIFEST)
                            begin
                                if (manifest_seen_reg)
                                begin
                                    chunk_err = ccd_pkg::STATUS_MANIFEST_TWICE;
                                end
                                else if (bp_inc != POS_MANIFEST)
                                begin
                                    chunk_err = ccd_pkg::STATUS_MANIFEST_LATE;
                                end
                                else
                                begin
                                    chunk_kind         = ccd_pkg::KIND_MANIFEST;
                                    manifest_seen_next = 1'b1;
                                end
                            end
                            else if (ws_shift == ccd_pkg::TYPE_BINARY)
                            begin
                                if (binary_seen_reg)
                                begin
                                    chunk_err = ccd_pkg::STATUS_BINARY_TWICE;
                                end
                                else
                                begin
                                    chunk_kind       = ccd_pkg::KIND_BINARY;
                                    binary_seen_next = 1'b1;
                                end
                            end
                            else if (ws_shift == ccd_pkg::TYPE_IMAGE)
                            begin
                                chunk_kind = ccd_pkg::KIND_IMAGE;
                            end

                            if (chunk_err != ccd_pkg::STATUS_BUSY)
                            begin
                                final_status_next = chunk_err;
                                phase_next        = ccd_pkg::PHASE_DRAIN;
                            end
                            else
                            begin
                                cur_kind_next = chunk_kind;
                                pad_left_next = 2'd0 - pay_left_reg[1:0];
                                if (pay_left_reg != '0)
                                begin
                                    phase_next = ccd_pkg::PHASE_PAY;
                                end
                                else if (bound_run)
                                begin
                                    // empty chunk: straight to the next header
                                    phase_next = ccd_pkg::PHASE_CHUNK;
                                end
                                else
                                begin
                                    phase_next = ccd_pkg::PHASE_DRAIN;
                                end
                            end
                        end
                    end

                    ccd_pkg::PHASE_PAY:
                    begin
                        result.payload_byte = in_data.data_byte;
                        result.chunk_kind   = cur_kind_reg;
                        result.payload_valid = cur_kind_reg inside
                            {ccd_pkg::KIND_MANIFEST, ccd_pkg::KIND_BINARY,
                             ccd_pkg::KIND_IMAGE};
                        pay_left_next = pay_dec;
                        if (pay_dec == '0)
                        begin
                            result.chunk_last = 1'b1;
                            if (pad_left_reg != 2'd0)
                            begin
                                phase_next = ccd_pkg::PHASE_PAD;
                            end
                            else if (bound_run)
                            begin
                                phase_next     = ccd_pkg::PHASE_CHUNK;
                                hdr_count_next = 3'd0;
                            end
                            else
                            begin
                                phase_next = ccd_pkg::PHASE_DRAIN;
                            end
                        end
                    end

                    ccd_pkg::PHASE_PAD:
                    begin
                        pad_left_next = pad_dec;
                        if (pad_dec == 2'd0)
                        begin
                            if (bound_run)
                            begin
                                phase_next     = ccd_pkg::PHASE_CHUNK;
                                hdr_count_next = 3'd0;
                            end
                            else
                            begin
                                phase_next = ccd_pkg::PHASE_DRAIN;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase

                // file complete at the total length
                if (!finished && phase_next != ccd_pkg::PHASE_HEADER
                    && bp_inc == total_next)
                begin
                    if (final_status_next != ccd_pkg::STATUS_BUSY)
                    begin
                        result.status = final_status_next;
                    end
                    else if (manifest_seen_next)
                    begin
                        result.status = ccd_pkg::STATUS_ACCEPTED;
                    end
                    else
                    begin
                        result.status = ccd_pkg::STATUS_NO_MANIFEST;
                    end
                    phase_next = ccd_pkg::PHASE_DONE;
                    finished   = 1'b1;
                end

                if (!finished && in_data.last_byte)
                begin
                    result.status = (bp_inc < POS_HDR_END) ? ccd_pkg::STATUS_SHORT
                                                           : ccd_pkg::STATUS_TOTAL_EXCEEDS;
                end
            end

            // last byte always starts a new file
            if (in_data.last_byte)
            begin
                phase_next         = ccd_pkg::PHASE_HEADER;
                byte_pos_next      = '0;
                total_next         = '0;
                word_shift_next    = '0;
                hdr_count_next     = 3'd0;
                pay_left_next      = '0;
                len_big_next       = 1'b0;
                pad_left_next      = 2'd0;
                cur_kind_next      = ccd_pkg::KIND_NONE;
                manifest_seen_next = 1'b0;
                binary_seen_next   = 1'b0;
                final_status_next  = ccd_pkg::STATUS_BUSY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ccd_pkg::PHASE_HEADER;
            byte_pos_reg      <= '0;
            total_reg         <= '0;
            word_shift_reg    <= '0;
            hdr_count_reg     <= 3'd0;
            pay_left_reg      <= '0;
            len_big_reg       <= 1'b0;
            pad_left_reg      <= 2'd0;
            cur_kind_reg      <= ccd_pkg::KIND_NONE;
            manifest_seen_reg <= 1'b0;
            binary_seen_reg   <= 1'b0;
            final_status_reg  <= ccd_pkg::STATUS_BUSY;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_pos_reg      <= byte_pos_next;
            total_reg         <= total_next;
            word_shift_reg    <= word_shift_next;
            hdr_count_reg     <= hdr_count_next;
            pay_left_reg      <= pay_left_next;
            len_big_reg       <= len_big_next;
            pad_left_reg      <= pad_left_next;
            cur_kind_reg      <= cur_kind_next;
            manifest_seen_reg <= manifest_seen_next;
            binary_seen_reg   <= binary_seen_next;
            final_status_reg  <= final_status_next;
        end
    end

    // output register plus skid entry
    logic               out_valid_reg;
    ccd_pkg::out_item_t out_data_reg;
    ccd_pkg::out_item_t skid_data_reg;
    logic               pop;

    assign pop       = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
